// ===== src/qsss_pkg.sv =====
// ----------------------------------------------------------------------------
// qsss_pkg - shared types and constants for the gain step search
// Word formats for both channels, search direction codes and fixed limits.
// ----------------------------------------------------------------------------
package qsss_pkg;

    typedef enum logic {
        ACT_START   = 1'b0,
        ACT_MEASURE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2,
        DIR_RSVD = 2'd3
    } dir_t;

    localparam logic [2:0]         START_EXPONENT  = 3'd4;
    localparam logic signed [16:0] TOP_BAND_MARGIN = 17'sd20;
    localparam logic [7:0]         GAIN_MAX        = 8'hFF;

    typedef struct packed {
        action_t     action;
        logic [7:0]  start_gain;
        logic [14:0] target_bits;
        logic [14:0] measured_bits;
    } item_t;

    typedef struct packed {
        logic [7:0]  gain;
        logic        done_res;
        logic [14:0] final_bits;
    } result_t;

endpackage

// ===== src/quantizer_step_size_search_core.sv =====
// ----------------------------------------------------------------------------
// quantizer_step_size_search_core - global gain step search
// One search iteration per input word: start words load gain and budget,
// measure words pick the step from threshold ladders and move the gain or end the search.
// ----------------------------------------------------------------------------
// Each word is registered, processed against the search state and lands in
// the result register, from which its result is presented. A new word is
// taken every cycle while the result register is not stalled. The only
// recurrence is the search state update, which completes in the same cycle
// as the result is formed, so consecutive words always see the state left
// by their predecessor. The result register is refilled while a stalled
// result waits only once the downstream side takes it.
module quantizer_step_size_search_core
    import qsss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic        in_valid_reg;
    item_t       in_reg;
    logic        res_valid_reg;
    result_t     res_reg;

    logic [14:0]        budget_reg, budget_next;
    logic [7:0]         gain_reg, gain_next;
    logic [2:0]         exp_reg, exp_next;
    dir_t               dir_reg, dir_next;
    logic signed [16:0] best_reg, best_next;
    result_t            res_next;

    logic        advance;
    logic        take;

    logic [14:0]        t, b, excess;
    logic [15:0]        t_x2;
    logic [16:0]        t_x3;
    logic [14:0]        t_34, t_38, t_half, t_quarter;
    logic signed [16:0] t_s, shortfall, t_m20;
    logic               over;
    logic [2:0]         k_up, k_dn, k_sel, exp_dec, exp_new;
    logic [7:0]         step;
    logic [8:0]         up_sum;
    logic               finish;

    // Move the held word on when the result slot is free or being taken.
    assign advance    = !res_valid_reg || !result_stall;
    assign item_stall = in_valid_reg && !advance;
    assign take       = item_valid && !item_stall;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        t         = budget_reg;
        b         = in_reg.measured_bits;
        over      = b > t;
        excess    = b - t;
        t_x2      = {t, 1'b0};
        t_x3      = {2'b00, t} + {1'b0, t, 1'b0};
        t_34      = t_x3[16:2];
        t_38      = {1'b0, t_x3[16:3]};
        t_half    = {1'b0, t[14:1]};
        t_quarter = {2'b00, t[14:2]};
        t_s       = signed'({2'b00, t});
        shortfall = t_s - signed'({2'b00, b});
        t_m20     = t_s - TOP_BAND_MARGIN;

        priority if ({1'b0, excess} >= t_x2) k_up = 3'd4;
        else if (excess >= t)                k_up = 3'd3;
        else if (excess >= t_34)             k_up = 3'd2;
        else if (excess >= t_half)           k_up = 3'd1;
        else                                 k_up = 3'd0;

        priority if (shortfall >= t_m20)                    k_dn = 3'd4;
        else if (shortfall >= signed'({2'b00, t_half}))     k_dn = 3'd3;
        else if (shortfall >= signed'({2'b00, t_38}))       k_dn = 3'd2;
        else if (shortfall >= signed'({2'b00, t_quarter}))  k_dn = 3'd1;
        else                                                k_dn = 3'd0;

        exp_dec = (exp_reg == 3'd0) ? 3'd0 : exp_reg - 3'd1;
        k_sel   = over ? k_up : k_dn;

        // Halve the step on a reversal, else clamp it to the ladder pick.
        if ((over && dir_reg == DIR_DOWN) || (!over && dir_reg == DIR_UP))
            exp_new = exp_dec;
        else
            exp_new = (k_sel < exp_reg) ? k_sel : exp_reg;

        step   = 8'd1 << exp_new;
        up_sum = {1'b0, gain_reg} + {1'b0, step};
        finish = !over && (shortfall == 17'sd0 || shortfall == best_reg
                 || shortfall < signed'({2'b00, t_quarter}));

        budget_next = budget_reg;
        gain_next   = gain_reg;
        exp_next    = exp_reg;
        dir_next    = dir_reg;
        best_next   = best_reg;
        res_next    = '0;

        unique case (in_reg.action)
            ACT_START:
            begin
                budget_next = in_reg.target_bits;
                gain_next   = in_reg.start_gain;
                exp_next    = START_EXPONENT;
                dir_next    = DIR_NONE;
                best_next   = signed'({2'b00, in_reg.target_bits}) - 17'sd1;
                res_next.gain = in_reg.start_gain;
            end
            ACT_MEASURE:
            begin
                exp_next = exp_new;
                if (over)
                begin
                    gain_next = up_sum[8] ? GAIN_MAX : up_sum[7:0];
                    dir_next  = DIR_UP;
                    res_next.gain = gain_next;
                end
                else if (finish)
                begin
                    res_next.gain       = gain_reg;
                    res_next.done_res   = 1'b1;
                    res_next.final_bits = b;
                end
                else
                begin
                    if (shortfall < best_reg)
                        best_next = shortfall;
                    gain_next = (gain_reg < step) ? 8'd0 : gain_reg - step;
                    dir_next  = DIR_DOWN;
                    res_next.gain = gain_next;
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            budget_reg    <= '0;
            gain_reg      <= '0;
            exp_reg       <= START_EXPONENT;
            dir_reg       <= DIR_NONE;
            best_reg      <= '0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                res_valid_reg <= in_valid_reg;

            // Commit the search state only when the word moves on.
            if (advance && in_valid_reg)
            begin
                budget_reg <= budget_next;
                gain_reg   <= gain_next;
                exp_reg    <= exp_next;
                dir_reg    <= dir_next;
                best_reg   <= best_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= item;
        if (advance && in_valid_reg)
            res_reg <= res_next;
    end

endmodule
